/* rtl/hpg_pkg.sv */
// shared widths, types and the cordic arctangent table of the hypocycloid point generator
`default_nettype none

package hpg_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int RATIO_FRAC_DEF = 16;
  localparam int TRIG_STAGES_DEF = 16;

  localparam int POS_W = 16;
  localparam int RATIO_W = 24;
  localparam int M_W = 26;
  localparam int PROD_W = M_W + POS_W;
  localparam int Z_W = 34;
  localparam int T_W = 34;
  localparam int COORD_W = 32;
  localparam int ATAN_COUNT = 24;

  localparam logic signed [T_W-1:0] CORDIC_GAIN = T_W'(652032874);

  typedef struct packed {
    logic signed [Z_W-1:0] z;
    logic                  flip;
  } angle_t;

  typedef struct packed {
    angle_t first;
    angle_t second;
  } phase_t;

  typedef struct packed {
    logic signed [T_W-1:0] cos1;
    logic signed [T_W-1:0] sin1;
    logic signed [T_W-1:0] cos2;
    logic signed [T_W-1:0] sin2;
  } trig_t;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051D;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2F9;
      15:      v = 32'h0000_517D;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A30;
      19:      v = 32'h0000_0518;
      20:      v = 32'h0000_028C;
      21:      v = 32'h0000_0146;
      22:      v = 32'h0000_00A3;
      23:      v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/hpg_phase.sv */
// phase front end: ratio product, both turn phases and the quadrant fold
`default_nettype none

module hpg_phase import hpg_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int RATIO_FRACTION_BITS = RATIO_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic signed [M_W-1:0] ratio_m,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [POS_W-1:0]      position,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output phase_t                     out_phase
);

  localparam int SHIFT = POS_W + RATIO_FRACTION_BITS - PHASE_BITS;
  localparam logic [31:0] KEEP = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

  logic                     va_r, vb_r;
  logic                     en_a, en_b;
  logic [POS_W-1:0]         pos_a_r;
  logic signed [PROD_W-1:0] prod_a_r;
  logic signed [PROD_W-1:0] prod_nxt;
  phase_t                   phase_b_r;
  phase_t                   phase_nxt;
  logic [31:0]              th1, th2;
  logic [PHASE_BITS-1:0]    ph2;

  function automatic angle_t fold(input logic [31:0] theta);
    angle_t      a;
    logic [31:0] t;
    a.flip = theta[31] ^ theta[30];
    t = a.flip ? (theta ^ 32'h8000_0000) : theta;
    a.z = Z_W'(signed'(t));
    return a;
  endfunction

  assign en_b = !vb_r || out_ready;
  assign en_a = !va_r || en_b;
  assign in_ready = en_a;

  assign prod_nxt = PROD_W'(ratio_m) * PROD_W'($signed(position));

  assign th1 = {pos_a_r, {(32 - POS_W){1'b0}}} & KEEP;
  assign ph2 = prod_a_r[SHIFT +: PHASE_BITS];
  assign th2 = 32'(ph2) << (32 - PHASE_BITS);

  always_comb begin
    phase_nxt.first = fold(th1);
    phase_nxt.second = fold(th2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      pos_a_r <= position;
      prod_a_r <= prod_nxt;
    end
    if (en_b && va_r) begin
      phase_b_r <= phase_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_phase = phase_b_r;

endmodule

`default_nettype wire

/* rtl/hpg_cordic.sv */
// two-lane pipelined rotation cordic, one iteration per stage, then the half-turn sign fix
`default_nettype none

module hpg_cordic import hpg_pkg::*; #(
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire phase_t in_phase,
  output logic        out_valid,
  input  wire logic   out_ready,
  output trig_t       out_trig
);

  localparam int N = (TRIG_STAGES > ATAN_COUNT) ? ATAN_COUNT : TRIG_STAGES;

  logic                  v_r [N+1];
  logic                  en  [N+1];
  logic signed [T_W-1:0] x_r [2][N];
  logic signed [T_W-1:0] y_r [2][N];
  logic signed [Z_W-1:0] z_r [2][N-1];
  logic                  flip_r [2][N];
  logic signed [T_W-1:0] cos_r [2];
  logic signed [T_W-1:0] sin_r [2];
  angle_t                ang [2];

  assign ang[0] = in_phase.first;
  assign ang[1] = in_phase.second;

  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign en[N] = !v_r[N] || out_ready;
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) v_r[k] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k <= N; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [T_W-1:0] xi, yi, x_nxt, y_nxt;
      logic signed [Z_W-1:0] zi, z_nxt, step;
      logic                  fi, vin;

      if (i == 0) begin : g_first
        assign xi = CORDIC_GAIN;
        assign yi = '0;
        assign zi = ang[l].z;
        assign fi = ang[l].flip;
        assign vin = in_valid;
      end else begin : g_next
        assign xi = x_r[l][i-1];
        assign yi = y_r[l][i-1];
        assign zi = z_r[l][i-1];
        assign fi = flip_r[l][i-1];
        assign vin = v_r[i-1];
      end

      assign step = Z_W'(atan_turn(i));

      always_comb begin
        if (!zi[Z_W-1]) begin
          x_nxt = xi - (yi >>> i);
          y_nxt = yi + (xi >>> i);
          z_nxt = zi - step;
        end else begin
          x_nxt = xi + (yi >>> i);
          y_nxt = yi - (xi >>> i);
          z_nxt = zi + step;
        end
      end

      always_ff @(posedge clk) begin
        if (en[i] && vin) begin
          x_r[l][i] <= x_nxt;
          y_r[l][i] <= y_nxt;
          flip_r[l][i] <= fi;
        end
      end

      if (i < N - 1) begin : g_zreg
        always_ff @(posedge clk) begin
          if (en[i] && vin) z_r[l][i] <= z_nxt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[N] && v_r[N-1]) begin
        cos_r[l] <= flip_r[l][N-1] ? -x_r[l][N-1] : x_r[l][N-1];
        sin_r[l] <= flip_r[l][N-1] ? -y_r[l][N-1] : y_r[l][N-1];
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_trig.cos1 = cos_r[0];
  assign out_trig.sin1 = sin_r[0];
  assign out_trig.cos2 = cos_r[1];
  assign out_trig.sin2 = sin_r[1];

  a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[N] |-> in_ready)
    else $error("cordic refuses a transfer with an empty last stage");

  a_transfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transfer missing from first cordic stage");

  a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N] && !out_ready |=> v_r[N] && $stable(out_trig))
    else $error("stalled cordic result changed");

endmodule

`default_nettype wire

/* rtl/hpg_combine.sv */
// weighted sum of both terms, round half up and saturate to the output format
`default_nettype none

module hpg_combine import hpg_pkg::*; #(
  parameter int RATIO_FRACTION_BITS = RATIO_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic signed [M_W-1:0] ratio_m,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire trig_t                 in_trig,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_W-1:0]         x_coord,
  output logic [COORD_W-1:0]         y_coord
);

  localparam int MP_W = M_W + T_W;
  localparam int ACC_W = MP_W + 1;
  localparam int RND_SH = RATIO_FRACTION_BITS + 14;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (RATIO_FRACTION_BITS + 13);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (COORD_W - 1));

  logic                   va_r, vb_r;
  logic                   en_a, en_b;
  logic signed [MP_W-1:0] px_r, py_r;
  logic signed [T_W-1:0]  qx_r, qy_r;
  logic [COORD_W-1:0]     x_r, y_r;

  function automatic logic [COORD_W-1:0] finish(input logic signed [MP_W-1:0] p,
                                                input logic signed [T_W-1:0] q);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] r;
    logic [COORD_W-1:0]      res;
    acc = ACC_W'(p) + (ACC_W'(q) <<< RATIO_FRACTION_BITS) + ROUND;
    r = acc >>> RND_SH;
    if (r > SAT_HI) res = SAT_HI[COORD_W-1:0];
    else if (r < SAT_LO) res = SAT_LO[COORD_W-1:0];
    else res = r[COORD_W-1:0];
    return res;
  endfunction

  assign en_b = !vb_r || out_ready;
  assign en_a = !va_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      px_r <= MP_W'(ratio_m) * MP_W'(in_trig.cos1);
      py_r <= MP_W'(ratio_m) * MP_W'(in_trig.sin1);
      qx_r <= in_trig.cos2;
      qy_r <= in_trig.sin2;
    end
    if (en_b && va_r) begin
      x_r <= finish(px_r, qx_r);
      y_r <= finish(py_r, qy_r);
    end
  end

  assign out_valid = vb_r;
  assign x_coord = x_r;
  assign y_coord = y_r;

endmodule

`default_nettype wire

/* rtl/hypocycloid_point_generator.sv */
// hypocycloid point generator top level: ratio register, phase, cordic and combine pipeline
//
//  channel  direction  payload                                  transfer when
//  in_      slave      position (16, signed Q1.15)              in_tvalid & in_tready
//  out_     master     x_coord (32), y_coord (32), Q15.16       out_tvalid & out_tready
//  cfg_     slave      shape_ratio (24, signed, ratio fraction)  cfg_valid & cfg_ready
//
// one point per clock sustained while out_tready is high; the stages, in order:
// two phase stages, one stage per cordic iteration plus a sign stage, two combine stages.
// every stage has its own valid bit and fills bubbles, so a stalled output only blocks
// the input once the whole pipeline is full.
// synchronous active-low reset empties the pipeline and sets the ratio to zero.
// cfg_ready is always high.
`default_nettype none

module hypocycloid_point_generator import hpg_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int RATIO_FRACTION_BITS = RATIO_FRAC_DEF,
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [15:0]        in_tdata,   // [15:0] position
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [63:0]             out_tdata,  // [31:0] x_coord, [63:32] y_coord
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [RATIO_W-1:0] cfg_data    // [23:0] shape_ratio
);

  localparam logic signed [M_W-1:0] RATIO_ONE = M_W'(1) <<< RATIO_FRACTION_BITS;

  logic signed [M_W-1:0] m_r, m_nxt;
  logic                  ph_valid, ph_ready;
  phase_t                ph_data;
  logic                  tr_valid, tr_ready;
  trig_t                 tr_data;
  logic [COORD_W-1:0]    x_coord, y_coord;

  assign cfg_ready = 1'b1;
  assign m_nxt = M_W'(signed'(cfg_data)) - RATIO_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= -RATIO_ONE;
    end else if (cfg_valid && cfg_ready) begin
      m_r <= m_nxt;
    end
  end

  hpg_phase #(
    .PHASE_BITS(PHASE_BITS),
    .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
  ) u_phase (
    .clk(clk),
    .rst_n(rst_n),
    .ratio_m(m_r),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .position(in_tdata),
    .out_valid(ph_valid),
    .out_ready(ph_ready),
    .out_phase(ph_data)
  );

  hpg_cordic #(
    .TRIG_STAGES(TRIG_STAGES)
  ) u_cordic (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(ph_valid),
    .in_ready(ph_ready),
    .in_phase(ph_data),
    .out_valid(tr_valid),
    .out_ready(tr_ready),
    .out_trig(tr_data)
  );

  hpg_combine #(
    .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
  ) u_combine (
    .clk(clk),
    .rst_n(rst_n),
    .ratio_m(m_r),
    .in_valid(tr_valid),
    .in_ready(tr_ready),
    .in_trig(tr_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .x_coord(x_coord),
    .y_coord(y_coord)
  );

  assign out_tdata = {y_coord, x_coord};

endmodule

`default_nettype wire

/* tb/tb_hypocycloid_point_generator.sv */
// self-checking testbench for the hypocycloid point generator, predictor-based, random idling
module tb_hypocycloid_point_generator;
  import hpg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = TRIG_STAGES_DEF + 20;
  localparam int CORDIC_STEPS = (TRIG_STAGES_DEF > 24) ? 24 : TRIG_STAGES_DEF;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int HOLD_AT_FIRST = 60;
  localparam int HOLD_AT_SECOND = 400;
  localparam int HOLD_CYCLES = 150;
  localparam int SCRIPT_ROWS = 30;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint ONE_RATIO = 64'sd65536;
  localparam logic [31:0] ARCTAN_TURNS [0:23] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };
  localparam logic [31:0] UNIT_X = 32'h0001_0000;

  typedef enum logic {ROW_RATIO, ROW_POSITION} row_kind_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [RATIO_W-1:0] value;
    logic               fix_x;
    logic [COORD_W-1:0] x_val;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [POS_W-1:0] in_tdata;     // [15:0] position
  logic out_tvalid;
  logic out_tready;
  logic [2*COORD_W-1:0] out_tdata; // [31:0] x_coord, [63:32] y_coord
  logic cfg_valid;
  logic cfg_ready;
  logic [RATIO_W-1:0] cfg_data;   // [23:0] shape_ratio

  point_t points_due[$];
  logic [RATIO_W-1:0] ratio_now;
  bit gaps_on;
  int err_count;
  int points_sent;
  int points_seen;
  int ratio_writes;
  int cycle_count = 0;
  script_row_t script [0:SCRIPT_ROWS-1];

  hypocycloid_point_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hypocycloid_point_generator test failed");
      $finish;
    end
  end

  // rotation-mode cordic on a 32-bit turn fraction, folded into the right half plane
  task automatic rotate_unit(input logic [31:0] theta, output longint c, output longint s);
    logic [31:0] t;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    t = theta;
    flip = 1'b0;
    if (t[31:30] == 2'b01 || t[31:30] == 2'b10) begin
      t = t - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(t));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ARCTAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ARCTAN_TURNS[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [COORD_W-1:0] mix_terms(input longint m, input longint t1,
                                                   input longint t2);
    longint acc;
    longint r;
    acc = m * t1 + t2 * ONE_RATIO;
    r = (acc + (64'sd1 <<< 29)) >>> 30;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[COORD_W-1:0];
  endfunction

  task automatic curve_point(input logic [POS_W-1:0] pos, input logic [RATIO_W-1:0] ratio,
                             output point_t pt);
    longint p;
    longint m;
    longint prod;
    longint c1;
    longint s1;
    longint c2;
    longint s2;
    logic [31:0] th1;
    logic [31:0] th2;
    p = longint'($signed(pos));
    m = longint'($signed(ratio)) - ONE_RATIO;
    prod = m * p;
    th1 = {pos, 16'h0000};
    th2 = {prod[31:16], 16'h0000};
    rotate_unit(th1, c1, s1);
    rotate_unit(th2, c2, s2);
    pt.x = mix_terms(m, c1, c2);
    pt.y = mix_terms(m, s1, s2);
  endtask

  task automatic offer_position(input logic [POS_W-1:0] pos, input logic fix_x,
                                input logic [COORD_W-1:0] x_val);
    int     gap;
    point_t want;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    curve_point(pos, ratio_now, want);
    if (fix_x) want.x = x_val;
    in_tvalid <= 1'b1;
    in_tdata <= pos;
    do @(posedge clk); while (!in_tready);
    points_due.push_back(want);
    points_sent++;
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    in_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ratio_now = value;
    ratio_writes++;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        3:       return 16'hFFFF;
        4:       return 16'h4000;
        default: return 16'hC000;
      endcase
    end
    return POS_W'($urandom);
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio(input int phase);
    case (phase)
      1:       return 24'h80_0000;
      2:       return RATIO_W'($urandom_range(2, 8) << 16);
      4:       return 24'h7F_FFFF;
      5:       return RATIO_W'(int'($urandom_range(0, 2097151)) - 1048576);
      6:       return 24'h00_0000;
      default: return RATIO_W'($urandom);
    endcase
  endfunction

  // result side: random stalls, two long hold-offs, compare every transfer
  initial begin : point_sink
    int     wait_cycles;
    point_t got;
    point_t want;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      wait_cycles = gaps_on ? $urandom_range(0, 4) : 0;
      if (points_seen == HOLD_AT_FIRST || points_seen == HOLD_AT_SECOND)
        wait_cycles = HOLD_CYCLES;
      if (wait_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      points_seen++;
      if (points_due.size() == 0) begin
        $display("%0t: point with no input pending, actual x %h y %h", $time, got.x, got.y);
        err_count++;
      end else begin
        want = points_due.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: x_coord mismatch, expected %h actual %h", $time, want.x, got.x);
          err_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: y_coord mismatch, expected %h actual %h", $time, want.y, got.y);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    ratio_now = '0;
    gaps_on = 1'b1;
    err_count = 0;
    points_sent = 0;
    points_seen = 0;
    ratio_writes = 0;

    // ratio zero after reset, then a = 1 where x is exactly cos(0), then both extremes, a = 3
    script = '{
      '{ROW_POSITION, 24'h00_0000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_7FFF, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_8000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_FFFF, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_4000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_C000, 1'b0, 32'h0},
      '{ROW_RATIO,    24'h01_0000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_0000, 1'b1, UNIT_X},
      '{ROW_POSITION, 24'h00_7FFF, 1'b1, UNIT_X},
      '{ROW_POSITION, 24'h00_8000, 1'b1, UNIT_X},
      '{ROW_POSITION, 24'h00_4000, 1'b1, UNIT_X},
      '{ROW_POSITION, 24'h00_C000, 1'b1, UNIT_X},
      '{ROW_POSITION, 24'h00_0001, 1'b1, UNIT_X},
      '{ROW_RATIO,    24'h7F_FFFF, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_0000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_7FFF, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_8000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_2000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_FFFF, 1'b0, 32'h0},
      '{ROW_RATIO,    24'h80_0000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_0000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_7FFF, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_8000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_2000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_FFFF, 1'b0, 32'h0},
      '{ROW_RATIO,    24'h03_0000, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_5555, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_2AAB, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_AAAB, 1'b0, 32'h0},
      '{ROW_POSITION, 24'h00_D556, 1'b0, 32'h0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_RATIO)
        write_ratio(script[r].value);
      else
        offer_position(script[r].value[POS_W-1:0], script[r].fix_x, script[r].x_val);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_ratio(pick_ratio(ph));
      gaps_on = !(ph == 2 || ph == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        offer_position(pick_position(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    gaps_on = 1'b1;
    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points checked across %0d ratio writes, both ratio extremes included,",
             points_seen, ratio_writes);
    $display("with random idling on both sides and two long output hold-offs");
    if (err_count == 0) begin
      $display("hypocycloid_point_generator test passed");
    end else begin
      $display("hypocycloid_point_generator test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hpg_pkg.sv
rtl/hpg_phase.sv
rtl/hpg_cordic.sv
rtl/hpg_combine.sv
rtl/hypocycloid_point_generator.sv
tb/tb_hypocycloid_point_generator.sv
